// ===== rtl/core/kti_pkg.sv =====
package kti_pkg;

   localparam int KTI_WORD_W = 32;
   localparam int KTI_FRAC_W = 16;
   localparam int KTI_QUOT_W = KTI_FRAC_W + 1;
   localparam int KTI_ALU_W  = KTI_WORD_W + 2;
   localparam int KTI_CNT_W  = 5;

   localparam logic ACT_INSERT  = 1'b0;
   localparam logic ACT_EVAL    = 1'b1;
   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   typedef enum logic [3:0] {
      KTI_IDLE,
      KTI_INS_RD,
      KTI_INS_CHK,
      KTI_INS_WR,
      KTI_EV_RD0,
      KTI_EV_CHK0,
      KTI_EV_RDL,
      KTI_EV_CHKL,
      KTI_EV_RDI,
      KTI_EV_CHKI,
      KTI_EV_SPAN,
      KTI_EV_DT,
      KTI_EV_DV,
      KTI_EV_DIV,
      KTI_EV_MUL,
      KTI_EV_ADD
   } kti_state_type;

   typedef enum logic {
      KTI_ALU_SUB,
      KTI_ALU_ADD
   } kti_alu_op_type;

   typedef struct packed {
      logic start;
   } kti_div_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } kti_div_stat_type;

endpackage

// ===== rtl/core/keyframe_track_interpolator.sv =====
// A full-table insert or an empty-table evaluate is answered straight from idle. An insert
// moves each key not earlier than the new one up one slot before writing the new key, and a
// query at or beyond the first or last key is clamped to that key's value. An interpolated
// query finds its bracket by a linear scan and divides in the bit-serial divider; the next
// request is taken once the block is back in idle and the output register is free.
// Reset (synchronous, active high) empties the table and drops any pending response.
module keyframe_track_interpolator
   import kti_pkg::*;
   #(parameter int MAX_KEYS = 16)
   (input  logic                         clock,
    input  logic                         reset,
    input  logic                         req_valid,
    output logic                         req_ready,
    input  logic                         req_action,
    input  logic signed [KTI_WORD_W-1:0] req_query_time,
    input  logic signed [KTI_WORD_W-1:0] req_key_value,
    output logic                         rsp_valid,
    input  logic                         rsp_ready,
    output logic signed [KTI_WORD_W-1:0] rsp_result_value,
    output logic [KTI_CNT_W-1:0]         rsp_stored_count,
    output logic                         rsp_status);

   localparam int AW = $clog2(MAX_KEYS);
   localparam int CW = $clog2(MAX_KEYS + 1);
   localparam int EW = 2 * KTI_WORD_W;
   localparam int PW = KTI_WORD_W + 1 + KTI_QUOT_W + 1;

   kti_state_type state_ff, state_in;

   logic [KTI_WORD_W-1:0] qtime_ff, qtime_in;
   logic [KTI_WORD_W-1:0] kval_ff, kval_in;
   logic [CW-1:0]         total_ff, total_in;
   logic [CW-1:0]         ptr_ff, ptr_in;
   logic [KTI_WORD_W-1:0] prev_time_ff, prev_time_in;
   logic [KTI_WORD_W-1:0] prev_val_ff, prev_val_in;
   logic [KTI_WORD_W-1:0] span_ff, span_in;
   logic [KTI_WORD_W-1:0] dt_ff, dt_in;
   logic [KTI_WORD_W:0]   dv_ff, dv_in;
   logic signed [PW-1:0]  prod_ff, prod_in;
   logic [KTI_WORD_W-1:0] res_val_ff, res_val_in;
   logic                  res_stat_ff, res_stat_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [KTI_WORD_W-1:0] rsp_val_ff, rsp_val_in;
   logic [KTI_CNT_W-1:0]  rsp_cnt_ff, rsp_cnt_in;
   logic                  rsp_stat_ff, rsp_stat_in;

   logic                  ram_wr_en, ram_rd_en;
   logic [AW-1:0]         ram_wr_addr, ram_rd_addr;
   logic [EW-1:0]         ram_wr_data, ram_rd_data;
   logic [KTI_WORD_W-1:0] rd_time, rd_val;

   kti_alu_op_type        alu_op;
   logic [KTI_ALU_W-1:0]  alu_a, alu_b, alu_res;
   logic                  alu_neg;

   kti_div_cmd_type       div_cmd;
   kti_div_stat_type      div_stat;
   logic [KTI_QUOT_W-1:0] div_quot;

   logic                  req_take, full;
   logic [CW-1:0]         ptr_dec, total_dec;
   logic [CW+KTI_CNT_W-1:0] total_ext;

   assign rd_time   = ram_rd_data[EW-1:KTI_WORD_W];
   assign rd_val    = ram_rd_data[KTI_WORD_W-1:0];
   assign req_take  = req_valid && req_ready;
   assign full      = (total_ff == CW'(MAX_KEYS));
   assign ptr_dec   = ptr_ff - 1'b1;
   assign total_dec = total_ff - 1'b1;
   assign total_ext = {{KTI_CNT_W{1'b0}}, total_ff};

   // Shared adder: every compare, difference and the final sum go through it.
   assign alu_res = (alu_op == KTI_ALU_ADD) ? alu_a + alu_b : alu_a - alu_b;
   assign alu_neg = alu_res[KTI_ALU_W-1];

   kti_ram #(.WIDTH(EW), .DEPTH(MAX_KEYS)) u_keys (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data));

   kti_div u_div (
      .clock    (clock),
      .reset    (reset),
      .cmd      (div_cmd),
      .dividend (dt_ff),
      .divisor  (span_ff),
      .stat     (div_stat),
      .quotient (div_quot));

   logic done_wait;
   logic out_free;
   assign out_free = !rsp_valid_ff || rsp_ready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         KTI_IDLE: begin
            if (req_take) begin
               if (req_action == ACT_EVAL) begin
                  state_in = (total_ff == '0) ? KTI_IDLE : KTI_EV_RD0;
               end else if (full) begin
                  state_in = KTI_IDLE;
               end else begin
                  state_in = (total_ff == '0) ? KTI_INS_WR : KTI_INS_RD;
               end
            end
         end
         KTI_INS_RD:  state_in = KTI_INS_CHK;
         KTI_INS_CHK: begin
            if (!alu_neg && ptr_ff != CW'(1)) begin
               state_in = KTI_INS_RD;
            end else begin
               state_in = KTI_INS_WR;
            end
         end
         KTI_INS_WR:  state_in = KTI_IDLE;
         KTI_EV_RD0:  state_in = KTI_EV_CHK0;
         KTI_EV_CHK0: state_in = alu_neg ? KTI_EV_RDL : KTI_IDLE;
         KTI_EV_RDL:  state_in = KTI_EV_CHKL;
         KTI_EV_CHKL: state_in = alu_neg ? KTI_EV_RDI : KTI_IDLE;
         KTI_EV_RDI:  state_in = KTI_EV_CHKI;
         KTI_EV_CHKI: state_in = alu_neg ? KTI_EV_RDI : KTI_EV_SPAN;
         KTI_EV_SPAN: state_in = KTI_EV_DT;
         KTI_EV_DT:   state_in = KTI_EV_DV;
         KTI_EV_DV:   state_in = KTI_EV_DIV;
         KTI_EV_DIV:  state_in = div_stat.done ? KTI_EV_MUL : KTI_EV_DIV;
         KTI_EV_MUL:  state_in = KTI_EV_ADD;
         KTI_EV_ADD:  state_in = KTI_IDLE;
         default:     state_in = KTI_IDLE;
      endcase
      // A finished transaction waits here until the output register is free.
      if (done_wait && !out_free) begin
         state_in = state_ff;
      end
   end

   // Finishing points of a transaction: the result is moved to the output register.
   always_comb begin
      done_wait = 1'b0;
      unique case (state_ff)
         KTI_IDLE:    done_wait = 1'b0;
         KTI_INS_WR:  done_wait = 1'b1;
         KTI_EV_CHK0: done_wait = !alu_neg;
         KTI_EV_CHKL: done_wait = !alu_neg;
         KTI_EV_ADD:  done_wait = 1'b1;
         default:     done_wait = 1'b0;
      endcase
   end

   // Outputs to the RAM, adder and divider.
   always_comb begin
      req_ready     = (state_ff == KTI_IDLE) && out_free;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = ptr_ff[AW-1:0];
      ram_wr_data   = ram_rd_data;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = ptr_ff[AW-1:0];
      alu_op        = KTI_ALU_SUB;
      alu_a         = {{2{rd_time[KTI_WORD_W-1]}}, rd_time};
      alu_b         = {{2{qtime_ff[KTI_WORD_W-1]}}, qtime_ff};
      div_cmd.start = 1'b0;
      unique case (state_ff)
         KTI_INS_RD: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = ptr_dec[AW-1:0];
         end
         KTI_INS_CHK: begin
            ram_wr_en = !alu_neg;
         end
         KTI_INS_WR: begin
            ram_wr_en   = 1'b1;
            ram_wr_data = {qtime_ff, kval_ff};
         end
         KTI_EV_RD0: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = '0;
         end
         KTI_EV_RDL: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = total_dec[AW-1:0];
         end
         KTI_EV_CHKL: begin
            alu_a = {{2{qtime_ff[KTI_WORD_W-1]}}, qtime_ff};
            alu_b = {{2{rd_time[KTI_WORD_W-1]}}, rd_time};
         end
         KTI_EV_RDI: begin
            ram_rd_en = 1'b1;
         end
         KTI_EV_SPAN: begin
            alu_b = {{2{prev_time_ff[KTI_WORD_W-1]}}, prev_time_ff};
         end
         KTI_EV_DT: begin
            alu_a = {{2{qtime_ff[KTI_WORD_W-1]}}, qtime_ff};
            alu_b = {{2{prev_time_ff[KTI_WORD_W-1]}}, prev_time_ff};
         end
         KTI_EV_DV: begin
            alu_a         = {{2{rd_val[KTI_WORD_W-1]}}, rd_val};
            alu_b         = {{2{prev_val_ff[KTI_WORD_W-1]}}, prev_val_ff};
            div_cmd.start = 1'b1;
         end
         KTI_EV_ADD: begin
            alu_op = KTI_ALU_ADD;
            alu_a  = {{2{prev_val_ff[KTI_WORD_W-1]}}, prev_val_ff};
            alu_b  = {prod_ff[KTI_WORD_W+KTI_FRAC_W], prod_ff[KTI_WORD_W+KTI_FRAC_W:KTI_FRAC_W]};
         end
         default: begin
         end
      endcase
   end

   // Datapath register updates.
   always_comb begin
      qtime_in     = qtime_ff;
      kval_in      = kval_ff;
      total_in     = total_ff;
      ptr_in       = ptr_ff;
      prev_time_in = prev_time_ff;
      prev_val_in  = prev_val_ff;
      span_in      = span_ff;
      dt_in        = dt_ff;
      dv_in        = dv_ff;
      prod_in      = prod_ff;
      res_val_in   = res_val_ff;
      res_stat_in  = res_stat_ff;
      unique case (state_ff)
         KTI_IDLE: begin
            if (req_take) begin
               qtime_in    = req_query_time;
               kval_in     = req_key_value;
               ptr_in      = total_ff;
               res_val_in  = '0;
               res_stat_in = (req_action == ACT_INSERT && full) ? STATUS_FULL : STATUS_OK;
            end
         end
         KTI_INS_CHK: begin
            if (!alu_neg) begin
               ptr_in = ptr_dec;
            end
         end
         KTI_INS_WR: begin
            total_in = total_ff + 1'b1;
         end
         KTI_EV_CHK0: begin
            prev_time_in = rd_time;
            prev_val_in  = rd_val;
            res_val_in   = rd_val;
         end
         KTI_EV_CHKL: begin
            res_val_in = rd_val;
            ptr_in     = CW'(1);
         end
         KTI_EV_CHKI: begin
            if (alu_neg) begin
               prev_time_in = rd_time;
               prev_val_in  = rd_val;
               ptr_in       = ptr_ff + 1'b1;
            end
         end
         KTI_EV_SPAN: span_in = alu_res[KTI_WORD_W-1:0];
         KTI_EV_DT:   dt_in   = alu_res[KTI_WORD_W-1:0];
         KTI_EV_DV:   dv_in   = alu_res[KTI_WORD_W:0];
         KTI_EV_MUL:  prod_in = PW'($signed(dv_ff) * $signed({1'b0, div_quot}));
         KTI_EV_ADD:  res_val_in = alu_res[KTI_WORD_W-1:0];
         default: begin
         end
      endcase
   end

   // Output register: loaded from the finishing state, or at once for the answers given from idle.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_val_in   = rsp_val_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      rsp_stat_in  = rsp_stat_ff;
      if (state_ff == KTI_IDLE && req_take && state_in == KTI_IDLE) begin
         rsp_valid_in = 1'b1;
         rsp_val_in   = '0;
         rsp_cnt_in   = total_ext[KTI_CNT_W-1:0];
         rsp_stat_in  = res_stat_in;
      end else if (done_wait && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_val_in   = res_val_in;
         rsp_cnt_in   = (state_ff == KTI_INS_WR) ? total_in[KTI_CNT_W-1:0] :
                                                   total_ext[KTI_CNT_W-1:0];
         rsp_stat_in  = STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= KTI_IDLE;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      qtime_ff     <= qtime_in;
      kval_ff      <= kval_in;
      ptr_ff       <= ptr_in;
      prev_time_ff <= prev_time_in;
      prev_val_ff  <= prev_val_in;
      span_ff      <= span_in;
      dt_ff        <= dt_in;
      dv_ff        <= dv_in;
      prod_ff      <= prod_in;
      res_val_ff   <= res_val_in;
      res_stat_ff  <= res_stat_in;
      rsp_val_ff   <= rsp_val_in;
      rsp_cnt_ff   <= rsp_cnt_in;
      rsp_stat_ff  <= rsp_stat_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_val_ff;
   assign rsp_stored_count = rsp_cnt_ff;
   assign rsp_status       = rsp_stat_ff;

   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      total_ff <= CW'(MAX_KEYS))
      else $error("key count exceeds table depth");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == KTI_INS_WR && out_free) |=> total_ff == CW'($past(total_ff) + 1'b1))
      else $error("insert did not add exactly one key");

   a_div_done_wait: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> state_ff == KTI_EV_DIV)
      else $error("divider finished outside its wait state");

   a_scan_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == KTI_EV_CHKI |-> (ptr_ff < total_ff) && (ptr_ff != '0))
      else $error("bracket search ran past the stored keys");

   a_full_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stat_ff == STATUS_FULL) |-> rsp_val_ff == '0)
      else $error("dropped insert carries a non-zero value");

endmodule

// ===== rtl/core/kti_ram.sv =====
module kti_ram
   #(parameter int WIDTH = 64,
     parameter int DEPTH = 16)
   (input  logic                     clock,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/kti_div.sv =====
module kti_div
   import kti_pkg::*;
   (input  logic                   clock,
    input  logic                   reset,
    input  kti_div_cmd_type        cmd,
    input  logic [KTI_WORD_W-1:0]  dividend,
    input  logic [KTI_WORD_W-1:0]  divisor,
    output kti_div_stat_type       stat,
    output logic [KTI_QUOT_W-1:0]  quotient);

   localparam int CNT_W = $clog2(KTI_QUOT_W);

   logic [KTI_WORD_W:0]   rem_ff, rem_in;
   logic [KTI_QUOT_W-1:0] quot_ff, quot_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [KTI_WORD_W+1:0] diff;
   logic                  ge;
   logic [KTI_WORD_W:0]   rem_kept;

   // The dividend never exceeds the divisor, so the quotient has one integer bit.
   assign diff     = {1'b0, rem_ff} - {2'b00, divisor};
   assign ge       = ~diff[KTI_WORD_W+1];
   assign rem_kept = ge ? diff[KTI_WORD_W:0] : rem_ff;

   always_comb begin
      rem_in  = rem_ff;
      quot_in = quot_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (cmd.start) begin
         rem_in  = {1'b0, dividend};
         quot_in = '0;
         cnt_in  = CNT_W'(KTI_QUOT_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = {rem_kept[KTI_WORD_W-1:0], 1'b0};
         quot_in = {quot_ff[KTI_QUOT_W-2:0], ge};
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = quot_ff;

endmodule
